// File: rtl/rpsm_pkg.sv
// Shared constants and types for the read pair sum matcher.
package rpsm_pkg;

    localparam int PAIR_ENTRIES = 4;
    localparam int BLOCK_BYTES  = 128;
    localparam int BLOCK_SHIFT  = $clog2(BLOCK_BYTES);
    localparam int ENTRY_IDX_W  = (PAIR_ENTRIES > 1) ? $clog2(PAIR_ENTRIES) : 1;

    localparam int DATA_W = 32;
    localparam int TAG_W  = 24;
    localparam int PADDR_W = 3;

    localparam logic [DATA_W-1:0] RESET_READ_BASE  = 32'h3000_0000;
    localparam logic [DATA_W-1:0] RESET_WRITE_BASE = 32'h4000_0000;

    // Register index, taken from paddr[2]
    localparam logic REG_READ_BASE  = 1'b0;
    localparam logic REG_WRITE_BASE = 1'b1;

    localparam logic [1:0] ST_STORED = 2'd0;
    localparam logic [1:0] ST_DONE   = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // Lookup and update request into the pair table
    typedef struct packed {
        logic              commit;
        logic [TAG_W-1:0]  tag;
        logic [DATA_W-1:0] sum;
    } t_tbl_req;

    // Lookup answer from the pair table
    typedef struct packed {
        logic              hit;
        logic              full;
        logic [DATA_W-1:0] hit_sum;
    } t_tbl_rsp;

endpackage

// File: rtl/rpsm_pair_table.sv
// Associative table of parked first-half sums, keyed by pair tag.
module rpsm_pair_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rpsm_pkg::t_tbl_req i_req,
    output rpsm_pkg::t_tbl_rsp o_rsp
);
    import rpsm_pkg::*;

    logic              r_valid [PAIR_ENTRIES];
    logic [TAG_W-1:0]  r_tag   [PAIR_ENTRIES];
    logic [DATA_W-1:0] r_psum  [PAIR_ENTRIES];

    logic                   hit;
    logic                   has_free;
    logic [ENTRY_IDX_W-1:0] hit_idx;
    logic [ENTRY_IDX_W-1:0] free_idx;

    // Lowest-numbered match and lowest-numbered free entry
    always_comb begin
        hit      = 1'b0;
        has_free = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = PAIR_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i]) begin
                if (r_tag[i] == i_req.tag) begin
                    hit     = 1'b1;
                    hit_idx = ENTRY_IDX_W'(i);
                end
            end else begin
                has_free = 1'b1;
                free_idx = ENTRY_IDX_W'(i);
            end
        end
    end

    assign o_rsp.hit     = hit;
    assign o_rsp.full    = !has_free;
    assign o_rsp.hit_sum = r_psum[hit_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PAIR_ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (i_req.commit) begin
            if (hit) begin
                r_valid[hit_idx] <= 1'b0;
            end else if (has_free) begin
                r_valid[free_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.commit && !hit && has_free) begin
            r_tag[free_idx]  <= i_req.tag;
            r_psum[free_idx] <= i_req.sum;
        end
    end

endmodule

// File: rtl/read_pair_sum_matcher_unit.sv
// Top level of the read pair sum matcher.
// A result reaches o_out_valid through the input register, the work stage and the result register.
// Throughput: one word per cycle while o_in_stall is low; the input register and the result register
// form a two-stage pipeline, and the pair table is searched in parallel.
// Reset (synchronous, active low): bases return to their defaults, the running
// sum clears and every table entry is freed.
module read_pair_sum_matcher_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rpsm_pkg::PADDR_W-1:0]        paddr,
    input  logic [rpsm_pkg::DATA_W-1:0]         pwdata,
    output logic [rpsm_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [rpsm_pkg::DATA_W-1:0]         i_rsp_addr,
    input  logic [rpsm_pkg::DATA_W-1:0]         i_data_word,
    input  logic                                i_last_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_status,
    output logic [rpsm_pkg::DATA_W-1:0]         o_result_addr,
    output logic [rpsm_pkg::DATA_W-1:0]         o_result_sum
);
    import rpsm_pkg::*;

    logic [DATA_W-1:0] r_read_base;
    logic [DATA_W-1:0] r_write_base;
    logic [DATA_W-1:0] r_running_sum;

    logic              r_in_valid;
    logic [DATA_W-1:0] r_diff;
    logic [DATA_W-1:0] r_word;
    logic              r_in_last;

    logic              r_out_valid;
    logic [1:0]        r_status;
    logic [DATA_W-1:0] r_result_addr;
    logic [DATA_W-1:0] r_result_sum;

    logic              out_blocked;
    logic              proc;
    logic              cfg_wr;
    logic [DATA_W-1:0] n_sum;
    logic [DATA_W-1:0] pair;
    logic [DATA_W-1:0] n_result_addr;
    logic [DATA_W-1:0] n_result_sum;
    logic [1:0]        n_status;
    t_tbl_req          tbl_req;
    t_tbl_rsp          tbl_rsp;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[2])
            REG_READ_BASE:  prdata = r_read_base;
            REG_WRITE_BASE: prdata = r_write_base;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_base  <= RESET_READ_BASE;
            r_write_base <= RESET_WRITE_BASE;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_READ_BASE:  r_read_base  <= pwdata;
                REG_WRITE_BASE: r_write_base <= pwdata;
                default: ;
            endcase
        end
    end

    // Handshake: the work stage advances whenever the result register can load
    assign out_blocked = r_out_valid && i_out_stall;
    assign proc        = r_in_valid && !out_blocked;
    assign o_in_stall  = r_in_valid && out_blocked;

    // Input register; the base offset is taken here, so the user must change bases only when idle (not enforced)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_diff    <= i_rsp_addr - r_read_base;
            r_word    <= i_data_word;
            r_in_last <= i_last_word;
        end
    end

    // Work stage
    assign n_sum = r_running_sum + r_word;
    assign pair  = r_diff >> (BLOCK_SHIFT + 1);

    assign tbl_req.commit = proc && r_in_last;
    assign tbl_req.tag    = pair[TAG_W-1:0];
    assign tbl_req.sum    = n_sum;

    rpsm_pair_table u_pair_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .o_rsp   (tbl_rsp)
    );

    always_comb begin
        n_result_addr = r_write_base + {pair[DATA_W-3:0], 2'b00};
        n_result_sum  = '0;
        if (tbl_rsp.hit) begin
            n_status     = ST_DONE;
            n_result_sum = tbl_rsp.hit_sum + n_sum;
        end else if (!tbl_rsp.full) begin
            n_status = ST_STORED;
        end else begin
            n_status = ST_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_sum <= '0;
        end else if (proc) begin
            // Clear on every last word, rejected blocks too: the replay resends them
            r_running_sum <= r_in_last ? '0 : n_sum;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!out_blocked) begin
            r_out_valid <= proc && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_in_last) begin
            r_status      <= n_status;
            r_result_addr <= n_result_addr;
            r_result_sum  <= n_result_sum;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_result_addr = r_result_addr;
    assign o_result_sum  = r_result_sum;

`ifndef NO_ASSERTIONS
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in_last |=> o_out_valid)
        else $error("last word did not produce a result");

    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in_last |=> r_running_sum == '0)
        else $error("running sum not cleared after last word");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while result side is free");
`endif

endmodule
